// ===== rtl/bfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared types, constants and the state-of-charge table of the fuel gauge.
// ----------------------------------------------------------------------------
package bfg_pkg;

  localparam int unsigned MaxPoints       = 16;
  localparam int unsigned SamplesPerGroup = 16;

  typedef enum logic [1:0] {
    REG_CAL_GAIN = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_CAPACITY = 2'd2,
    REG_LOAD     = 2'd3
  } reg_idx_t;

  // Command from controller to datapath
  typedef struct packed {
    logic acc;      // add sample to group sum
    logic scale;    // scale step; the sum * gain product is registered on the group's last acc
    logic filt;     // filter update
    logic soc;      // percent and flags
    logic rt_mul;   // capacity * percent * 3
    logic div_step; // one restoring step
    logic div2_load; // divide by 5 by reciprocal, start the divide by load
    logic finish;   // latch result
  } dp_cmd_t;

  typedef struct packed {
    logic group_done;
    logic div_done;
  } dp_sts_t;

  function automatic logic [12:0] soc_mv(input logic [3:0] i);
    case (i)
      4'd0:  soc_mv = 13'd3000;
      4'd1:  soc_mv = 13'd3300;
      4'd2:  soc_mv = 13'd3600;
      4'd3:  soc_mv = 13'd3700;
      4'd4:  soc_mv = 13'd3750;
      4'd5:  soc_mv = 13'd3790;
      4'd6:  soc_mv = 13'd3830;
      4'd7:  soc_mv = 13'd3870;
      4'd8:  soc_mv = 13'd3920;
      4'd9:  soc_mv = 13'd3970;
      4'd10: soc_mv = 13'd4100;
      default: soc_mv = 13'd4200;
    endcase
  endfunction

  function automatic logic [6:0] soc_pct(input logic [3:0] i);
    case (i)
      4'd0:  soc_pct = 7'd0;
      4'd1:  soc_pct = 7'd5;
      4'd2:  soc_pct = 7'd10;
      4'd3:  soc_pct = 7'd20;
      4'd4:  soc_pct = 7'd30;
      4'd5:  soc_pct = 7'd40;
      4'd6:  soc_pct = 7'd50;
      4'd7:  soc_pct = 7'd60;
      4'd8:  soc_pct = 7'd70;
      4'd9:  soc_pct = 7'd80;
      4'd10: soc_pct = 7'd90;
      default: soc_pct = 7'd100;
    endcase
  endfunction

endpackage

// ===== rtl/battery_fuel_gauge_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_fuel_gauge_top
// Averages ADC samples in groups, filters, and reports voltage and charge.
// ----------------------------------------------------------------------------
// Sample items are taken while the sequencer is idle; the last sample of a
// group stalls the input while gain, filter, table lookup, a reciprocal
// multiply for the divide by 5 and a 32-step restoring divide by the load
// current run on the shared datapath, and longer while a stalled receiver
// keeps the output register full. One result item leaves per completed group
// through an output register.
module battery_fuel_gauge_top #(
  parameter int unsigned TABLE_POINTS      = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_sample_mv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [12:0]        out_voltage_mv,
  output logic [6:0]         out_charge_percent,
  output logic               out_present,
  output logic               out_low_flag,
  output logic signed [22:0] out_runtime_minutes,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] gain_r, cap_r, load_r;
  logic [12:0] thr_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'd16384;
      thr_r  <= 13'd3300;
      cap_r  <= 16'd1000;
      load_r <= 16'd100;
    end else if (wr) begin
      case (paddr[3:2])
        bfg_pkg::REG_CAL_GAIN: gain_r <= pwdata[15:0];
        bfg_pkg::REG_LOW_THR:  thr_r  <= pwdata[12:0];
        bfg_pkg::REG_CAPACITY: cap_r  <= pwdata[15:0];
        bfg_pkg::REG_LOAD:     load_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bfg_pkg::REG_CAL_GAIN: prdata = {16'd0, gain_r};
      bfg_pkg::REG_LOW_THR:  prdata = {19'd0, thr_r};
      bfg_pkg::REG_CAPACITY: prdata = {16'd0, cap_r};
      bfg_pkg::REG_LOAD:     prdata = {16'd0, load_r};
      default:               prdata = '0;
    endcase
  end

  bfg_pkg::dp_cmd_t cmd;
  bfg_pkg::dp_sts_t sts;
  logic             res_load;
  logic             out_valid_r;
  logic [12:0]      mv;
  logic [6:0]       pct;
  logic             pres, lowf;
  logic signed [22:0] rtm;

  bfg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .res_load (res_load),
    .res_free (!out_valid_r || !out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfg_dp #(
    .TABLE_POINTS      (TABLE_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .sample_mv        (in_sample_mv),
    .cal_gain         (gain_r),
    .low_threshold_mv (thr_r),
    .capacity_mah     (cap_r),
    .load_ma          (load_r),
    .voltage_mv       (mv),
    .charge_percent   (pct),
    .present          (pres),
    .low_flag         (lowf),
    .runtime_minutes  (rtm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_voltage_mv      <= mv;
      out_charge_percent  <= pct;
      out_present         <= pres;
      out_low_flag        <= lowf;
      out_runtime_minutes <= rtm;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/bfg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_ctrl
// Sequencer: accepts items, steps the datapath through a group end.
// ----------------------------------------------------------------------------
module bfg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              res_load,
  input  logic              res_free,
  output bfg_pkg::dp_cmd_t  cmd,
  input  bfg_pkg::dp_sts_t  sts
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_FILT  = 8'b0000_0100,
    S_SOC   = 8'b0000_1000,
    S_RTM   = 8'b0001_0000,
    S_DIV1  = 8'b0010_0000,
    S_DIV2  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    res_load  = 1'b0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (sts.group_done) begin
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_FILT;
      end
      S_FILT: begin
        cmd.filt  = 1'b1;
        state_nxt = S_SOC;
      end
      S_SOC: begin
        cmd.soc   = 1'b1;
        state_nxt = S_RTM;
      end
      S_RTM: begin
        cmd.rt_mul   = 1'b1;
        state_nxt    = S_DIV1;
      end
      S_DIV1: begin
        cmd.div2_load = 1'b1;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (res_free) begin
          cmd.finish = 1'b1;
          res_load   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/bfg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_dp
// Datapath: group sum, gain, filter, table interpolation, runtime divider.
// ----------------------------------------------------------------------------
module bfg_dp #(
  parameter int unsigned TABLE_POINTS      = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bfg_pkg::dp_cmd_t  cmd,
  output bfg_pkg::dp_sts_t  sts,
  input  logic [11:0]       sample_mv,
  input  logic [15:0]       cal_gain,
  input  logic [12:0]       low_threshold_mv,
  input  logic [15:0]       capacity_mah,
  input  logic [15:0]       load_ma,
  output logic [12:0]       voltage_mv,
  output logic [6:0]        charge_percent,
  output logic              present,
  output logic              low_flag,
  output logic signed [22:0] runtime_minutes
);

  localparam int unsigned SHIFT = $clog2(bfg_pkg::SamplesPerGroup) + 6;
  localparam int unsigned PTS   = (TABLE_POINTS > 16) ? 16 : TABLE_POINTS;

  logic [15:0] sum_r;
  logic [3:0]  cnt_r;
  logic [31:0] prod_r;
  logic [20:0] filt_r;
  logic        primed_r;
  logic [6:0]  pct_r;
  logic        pres_r, low_r;
  logic [12:0] mv_r;
  logic [31:0] rt_r;       // dividend / quotient
  logic [16:0] rem_r;
  logic [16:0] dsr_r;
  logic [5:0]  dcnt_r;

  // scaled value: (sum*gain + 2^(S-1)) >> S, saturated
  logic [32:0] rnd;
  logic [20:0] v;
  assign rnd = {1'b0, prod_r} + (33'd1 << (SHIFT - 1));
  assign v   = (|(rnd >> (SHIFT + 21))) ? 21'h1F_FFFF : 21'(rnd >> SHIFT);

  logic [38:0] fsum;
  assign fsum = 39'(filt_r) * 39'd52429 + 39'(v) * 39'd13107 + 39'd32768;

  // interpolation: pick the segment, then round dlt*dp/den by comparing
  // twice the product against odd multiples of the segment width
  logic [6:0]  pct_c;
  logic [20:0] t0;
  always_comb begin
    logic        found;
    logic [3:0]  seg;
    logic [20:0] lo, hi, dlt, den;
    logic [3:0]  dp;
    logic [25:0] num2;
    logic [3:0]  q;
    found = 1'b0;
    seg   = 4'd0;
    t0    = {bfg_pkg::soc_mv(4'd0), 8'd0};
    for (int i = 1; i < 16; i++) begin
      if (!found && i < PTS && filt_r < {bfg_pkg::soc_mv(4'(i)), 8'd0}) begin
        found = 1'b1;
        seg   = 4'(i);
      end
    end
    lo   = {bfg_pkg::soc_mv(seg - 4'd1), 8'd0};
    hi   = {bfg_pkg::soc_mv(seg), 8'd0};
    dlt  = filt_r - lo;
    den  = hi - lo;
    dp   = 4'(bfg_pkg::soc_pct(seg) - bfg_pkg::soc_pct(seg - 4'd1));
    num2 = 26'({dlt, 1'b0}) * 26'(dp);
    q    = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (num2 >= 26'(den) * 26'(2 * k - 1)) q = q + 4'd1;
    end
    if (filt_r <= t0) begin
      pct_c = 7'd0;
    end else if (!found) begin
      pct_c = 7'd100;
    end else begin
      pct_c = bfg_pkg::soc_pct(seg - 4'd1) + 7'(q);
    end
  end

  logic [16:0] trial;
  assign trial = {rem_r[15:0], rt_r[31]} - dsr_r;
  logic        div_busy;
  assign div_busy = (dcnt_r != 6'd0);

  // divide by 5 exact for dividends below 2^25
  logic [51:0] rcp;
  assign rcp = 52'(rt_r[24:0]) * 52'd53687092;

  assign sts.group_done = ({28'd0, cnt_r} + 32'd1 >= 32'(bfg_pkg::SamplesPerGroup));
  assign sts.div_done   = !div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      cnt_r    <= '0;
      filt_r   <= '0;
      primed_r <= 1'b0;
      dcnt_r   <= '0;
    end else begin
      if (cmd.acc) begin
        if (sts.group_done) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_r + 16'(sample_mv);
          cnt_r <= cnt_r + 4'd1;
        end
      end
      if (cmd.filt) begin
        primed_r <= 1'b1;
        filt_r   <= primed_r ? 21'(fsum >> 16) : v;
      end
      if (cmd.div2_load) begin
        dcnt_r <= 6'd32;
      end else if (cmd.div_step && div_busy) begin
        dcnt_r <= dcnt_r - 6'd1;
      end
    end
  end

  logic [15:0] fsum_add;
  assign fsum_add = sum_r + 16'(sample_mv);

  always_ff @(posedge clk) begin
    if (cmd.acc && sts.group_done) begin
      prod_r <= 32'(fsum_add) * 32'(cal_gain);
    end
    if (cmd.soc) begin
      pct_r  <= pct_c;
      pres_r <= filt_r > 21'(2500 * 256);
      low_r  <= (filt_r > 21'(2500 * 256)) && (filt_r < {low_threshold_mv, 8'd0});
      mv_r   <= (filt_r[20:8] == 13'h1FFF && filt_r[7]) ? 13'h1FFF
              : 13'((22'(filt_r) + 22'd128) >> 8);
    end
    // capacity * percent * 60 / 100 = capacity * percent * 3 / 5
    if (cmd.rt_mul) begin
      rt_r <= 32'(capacity_mah) * 32'({pct_r, 1'b0} + {2'b0, pct_r});
    end
    if (cmd.div2_load) begin
      rt_r  <= {10'd0, rcp[49:28]};
      rem_r <= '0;
      dsr_r <= (load_ma == 16'd0) ? 17'd1 : {1'b0, load_ma};
    end
    if (cmd.div_step && div_busy) begin
      if (!trial[16]) begin
        rem_r <= trial;
        rt_r  <= {rt_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], rt_r[31]};
        rt_r  <= {rt_r[30:0], 1'b0};
      end
    end
  end

  assign voltage_mv      = mv_r;
  assign charge_percent  = pct_r;
  assign present         = pres_r;
  assign low_flag        = low_r;
  assign runtime_minutes = pres_r ? $signed(rt_r[22:0]) : -23'sd1;

endmodule

// ===== sim/battery_fuel_gauge_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_fuel_gauge_top_tb
// Drives ADC sample items into the fuel gauge under random valid and stall
// gaps, predicts each group result with an in-bench model of the averaging,
// gain, filter, table lookup and runtime divide, and compares field by field.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_top_tb;

  localparam int unsigned GROUP = bfg_pkg::SamplesPerGroup;
  localparam int unsigned POINTS = 12;
  localparam int unsigned SETTLE = 200;

  typedef struct packed {
    logic [12:0] voltage_mv;
    logic [6:0]  charge_percent;
    logic        present;
    logic        low_flag;
    logic [22:0] runtime_minutes;
  } gauge_result_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [11:0] in_sample_mv;
  logic out_valid, out_stall;
  logic [12:0] out_voltage_mv;
  logic [6:0] out_charge_percent;
  logic out_present, out_low_flag;
  logic signed [22:0] out_runtime_minutes;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  battery_fuel_gauge_top #(.TABLE_POINTS(POINTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_mv(in_sample_mv),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_voltage_mv(out_voltage_mv), .out_charge_percent(out_charge_percent),
    .out_present(out_present), .out_low_flag(out_low_flag),
    .out_runtime_minutes(out_runtime_minutes),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // gauge model state
  logic [15:0] gain_q14;
  logic [12:0] low_thr;
  logic [15:0] capacity;
  logic [15:0] load_cur;
  logic [15:0] group_sum;
  logic [3:0]  group_cnt;
  logic [20:0] filt_q8;
  logic        filt_loaded;

  logic [11:0]   pending_samples[$];
  gauge_result_t expected_results[$];
  int unsigned mismatches;
  bit quiet;          // no idling on either side
  bit hold_rx;        // long receiver hold-off request
  int unsigned in_gap, out_gap, hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [6:0] charge_of(input logic [20:0] f);
    logic [63:0] num, den, dp, lo;
    if (f <= 21'(bfg_pkg::soc_mv(4'd0)) * 256) return 7'd0;
    for (int i = 1; i < POINTS && i < 16; i++) begin
      if (f < 21'(bfg_pkg::soc_mv(4'(i))) * 256) begin
        lo = 64'(bfg_pkg::soc_mv(4'(i - 1))) * 256;
        dp = 64'(bfg_pkg::soc_pct(4'(i))) - 64'(bfg_pkg::soc_pct(4'(i - 1)));
        den = (64'(bfg_pkg::soc_mv(4'(i))) - 64'(bfg_pkg::soc_mv(4'(i - 1)))) * 256;
        num = (64'(f) - lo) * dp;
        if (den == 0) return bfg_pkg::soc_pct(4'(i - 1));
        return bfg_pkg::soc_pct(4'(i - 1)) + 7'((2 * num + den) / (2 * den));
      end
    end
    return 7'd100;
  endfunction

  task automatic accumulate_sample(input logic [11:0] s);
    logic [63:0] v, f, mv;
    logic [6:0] pct;
    gauge_result_t r;
    group_sum = group_sum + 16'(s);
    if (group_cnt + 1 < GROUP) begin
      group_cnt = group_cnt + 1;
      return;
    end
    v = (64'(group_sum) * gain_q14 * 256 + GROUP * 8192) / (GROUP * 16384);
    if (v > 64'h1FFFFF) v = 64'h1FFFFF;
    group_sum = '0;
    group_cnt = '0;
    if (!filt_loaded) begin
      f = v;
      filt_loaded = 1'b1;
    end else begin
      f = (64'(filt_q8) * 52429 + v * 13107 + 32768) >> 16;
    end
    filt_q8 = f[20:0];
    mv = (64'(filt_q8) + 128) >> 8;
    if (mv > 8191) mv = 8191;
    pct = charge_of(filt_q8);
    r.voltage_mv = mv[12:0];
    r.charge_percent = pct;
    r.present = filt_q8 > 21'd2500 * 256;
    r.low_flag = r.present && (filt_q8 < 21'(low_thr) * 256);
    if (!r.present) r.runtime_minutes = 23'h7FFFFF;
    else r.runtime_minutes = 23'((64'(capacity) * pct * 60 / 100) /
                                  (load_cur == 0 ? 64'd1 : 64'(load_cur)));
    expected_results.push_back(r);
  endtask

  task automatic write_reg(input bfg_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bfg_pkg::REG_CAL_GAIN: gain_q14 = val[15:0];
      bfg_pkg::REG_LOW_THR:  low_thr = val[12:0];
      bfg_pkg::REG_CAPACITY: capacity = val[15:0];
      bfg_pkg::REG_LOAD:     load_cur = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_idle();
    while (pending_samples.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_group(input int lo, input int hi);
    for (int k = 0; k < GROUP; k++)
      pending_samples.push_back(12'($urandom_range(hi, lo)));
  endtask

  // driver: the offered item stays at the head of the queue until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) void'(pending_samples.pop_front());
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        if (!quiet && $urandom_range(9, 0) == 0) begin
          in_gap <= $urandom_range(15, 0);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_sample_mv <= pending_samples[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // model fed at acceptance
  always @(posedge clk)
    if (rst_n && in_valid && !in_stall) accumulate_sample(in_sample_mv);

  // receiver stall and monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
      hold_cnt <= 0;
    end else begin
      if (hold_rx && hold_cnt == 0) begin
        hold_cnt <= 400;
        out_stall <= 1'b1;
      end else if (hold_cnt > 1) begin
        hold_cnt <= hold_cnt - 1;
      end else if (hold_cnt == 1) begin
        hold_cnt <= 0;
        hold_rx = 1'b0;
        out_stall <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall <= (out_gap != 1);
      end else if (!quiet && $urandom_range(7, 0) == 0) begin
        out_gap <= $urandom_range(16, 1);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          gauge_result_t e;
          e = expected_results.pop_front();
          if (e.voltage_mv !== out_voltage_mv || e.charge_percent !== out_charge_percent ||
              e.present !== out_present || e.low_flag !== out_low_flag ||
              e.runtime_minutes !== out_runtime_minutes) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: exp mv=%0d pct=%0d pr=%0b low=%0b rt=%0d, ",
                        "got mv=%0d pct=%0d pr=%0b low=%0b rt=%0d"},
                       e.voltage_mv, e.charge_percent, e.present, e.low_flag,
                       $signed(e.runtime_minutes), out_voltage_mv, out_charge_percent,
                       out_present, out_low_flag, out_runtime_minutes);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_sample_mv = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    quiet = 1'b0; hold_rx = 1'b0; mismatches = 0;
    gain_q14 = 16'd16384; low_thr = 13'd3300; capacity = 16'd1000; load_cur = 16'd100;
    group_sum = '0; group_cnt = '0; filt_q8 = '0; filt_loaded = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: low group primes the filter, then a full-scale group and two mid samples
    for (int k = 0; k < GROUP; k++) pending_samples.push_back(12'd0);
    for (int k = 0; k < GROUP; k++) pending_samples.push_back(12'hFFF);
    pending_samples.push_back(12'hAAA);
    pending_samples.push_back(12'h555);
    drain_and_idle();

    // extremes: max gain saturates, zero load, max threshold
    write_reg(bfg_pkg::REG_CAL_GAIN, 32'hFFFF);
    write_reg(bfg_pkg::REG_LOW_THR, 32'h1FFF);
    write_reg(bfg_pkg::REG_CAPACITY, 32'hFFFF);
    write_reg(bfg_pkg::REG_LOAD, 32'd0);
    for (int g = 0; g < 3; g++) queue_group(3800, 4095);
    drain_and_idle();

    // minimum gain drives the filter down, then sweep the table
    write_reg(bfg_pkg::REG_CAL_GAIN, 32'd0);
    write_reg(bfg_pkg::REG_LOW_THR, 32'd0);
    write_reg(bfg_pkg::REG_CAPACITY, 32'd0);
    write_reg(bfg_pkg::REG_LOAD, 32'hFFFF);
    for (int g = 0; g < 3; g++) queue_group(0, 4095);
    drain_and_idle();

    // random phases across settings; long receiver hold in the first one
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(bfg_pkg::REG_CAL_GAIN,
                ph == 0 ? 32'd16384 : $urandom_range(20000, 12000));
      write_reg(bfg_pkg::REG_LOW_THR, $urandom_range(4200, 2800));
      write_reg(bfg_pkg::REG_CAPACITY, $urandom_range(65535, 0));
      write_reg(bfg_pkg::REG_LOAD, $urandom_range(65535, 1));
      if (ph == 0) hold_rx = 1'b1;
      if (ph == 3) quiet = 1'b1;
      for (int g = 0; g < 5; g++) begin
        if (g == 4) queue_group(0, 4095);
        else queue_group(2900, 4300 > 4095 ? 4095 : 4300);
      end
      drain_and_idle();
    end
    // a few stray samples that leave a group open
    for (int k = 0; k < 5; k++) pending_samples.push_back(12'($urandom));
    drain_and_idle();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
